// ===== rtl/clle_pkg.sv =====
// Shared constants for the cursor linked list engine.
package clle_pkg;

	localparam int SLOTS = 1024;
	localparam int LINK_W = $clog2(SLOTS);
	localparam int POS_W = 10;
	localparam int CNT_W = 10;
	localparam int VAL_W = 32;
	localparam int ST_W = 2;

	localparam logic [LINK_W-1:0] HEAD_SLOT = LINK_W'(SLOTS - 1);
	localparam logic [LINK_W-1:0] LAST_FREE = LINK_W'(SLOTS - 2);

	localparam logic [ST_W-1:0] ST_OK = 2'd0;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL = 2'd2;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_DELETE = 1'b1;

endpackage

// ===== rtl/clle_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module clle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/cursor_linked_list_engine_top.sv =====
// Top level of the cursor linked list engine: sequencer around the link and value RAMs.
//
// Input channel s_*: one item per insert or delete. s_tuser carries the command
// (0 insert, 1 delete); s_tdata carries the 1-based position and the value.
// Output channel m_*: exactly one item per input item, carrying the status
// (0 ok, 1 position out of range, 2 no free slot) and the list length after it.
// Items are handled one at a time; s_tready is high only while the sequencer idles.
// A range error or a full list goes straight to the result. An insert takes a
// free slot, walks the links to the position and links the slot in; a delete
// walks to the position, unlinks the item and returns its slot to the free chain.
// The link walk reads one link per cycle from the link RAM, so the list
// position sets the latency; s_tready returns as the result is loaded into the
// output register, in the same cycle that m_tvalid rises.
// After reset a clearing pass writes the initial free chain into the link RAM,
// one slot a cycle, through all SLOTS (1024) slots; s_tready stays low until it ends.
// The result is held in an output register; while the receiver stalls the next
// item is still accepted and worked on, and its result waits until the held
// one is taken.
module cursor_linked_list_engine_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // [9:0] position, [41:10] value, [47:42] zero
	input  logic        s_tuser,  // [0] command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // [1:0] status, [11:2] list_length, [15:12] zero
);

	import clle_pkg::*;

	localparam logic [3:0] S_INIT  = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_ALLOC = 4'd2;
	localparam logic [3:0] S_WALK  = 4'd3;
	localparam logic [3:0] S_PRED  = 4'd4;
	localparam logic [3:0] S_VICT  = 4'd5;
	localparam logic [3:0] S_LINK  = 4'd6;
	localparam logic [3:0] S_FIN   = 4'd7;

	logic [3:0]        state_q;
	logic [LINK_W-1:0] init_q;
	logic [LINK_W-1:0] free_q;
	logic [LINK_W-1:0] nfree_q;
	logic [LINK_W-1:0] slot_q;
	logic [LINK_W-1:0] cur_q;
	logic [LINK_W-1:0] victim_q;
	logic [POS_W-1:0]  remain_q;
	logic              pend_q;
	logic              cmd_q;
	logic [VAL_W-1:0]  value_q;
	logic [CNT_W-1:0]  count_q;
	logic [ST_W-1:0]   res_q;
	logic [15:0]       out_q;
	logic              out_valid_q;

	logic [POS_W-1:0]  in_pos;
	logic [VAL_W-1:0]  in_val;
	logic              accept;
	logic              range_ok;
	logic [LINK_W-1:0] cur;

	logic              link_we;
	logic [LINK_W-1:0] link_waddr;
	logic [LINK_W-1:0] link_wdata;
	logic              link_re;
	logic [LINK_W-1:0] link_raddr;
	logic [LINK_W-1:0] link_rdata;
	logic              val_we;

	assign in_pos = s_tdata[POS_W-1:0];
	assign in_val = s_tdata[POS_W +: VAL_W];
	assign s_tready = (state_q == S_IDLE);
	assign accept = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata = out_q;
	assign cur = pend_q ? link_rdata : cur_q;

	always_comb begin
		if (s_tuser == CMD_INSERT) begin
			range_ok = (in_pos != '0) && ({1'b0, in_pos} <= ({1'b0, count_q} + 11'd1));
		end else begin
			range_ok = (in_pos != '0) && (in_pos <= count_q);
		end
	end

	always_comb begin
		link_we = 1'b0;
		link_waddr = cur_q;
		link_wdata = slot_q;
		link_re = 1'b0;
		link_raddr = cur;
		val_we = 1'b0;
		unique case (state_q)
			S_INIT: begin
				link_we = 1'b1;
				link_waddr = init_q;
				link_wdata = (init_q < LAST_FREE) ? init_q + LINK_W'(1) : '0;
			end
			S_IDLE: begin
				link_re = accept && range_ok && (s_tuser == CMD_INSERT) && (free_q != '0);
				link_raddr = free_q;
			end
			S_ALLOC: begin
				val_we = 1'b1;
			end
			S_WALK: begin
				link_re = 1'b1;
				link_raddr = cur;
			end
			S_PRED: begin
				if (cmd_q == CMD_INSERT) begin
					link_we = 1'b1;
					link_waddr = slot_q;
					link_wdata = link_rdata;
				end else begin
					link_re = 1'b1;
					link_raddr = link_rdata;
				end
			end
			S_VICT: begin
				link_we = 1'b1;
				link_waddr = cur_q;
				link_wdata = link_rdata;
			end
			S_LINK: begin
				link_we = 1'b1;
				if (cmd_q == CMD_INSERT) begin
					link_waddr = cur_q;
					link_wdata = slot_q;
				end else begin
					link_waddr = victim_q;
					link_wdata = free_q;
				end
			end
			S_FIN: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			init_q <= '0;
			free_q <= LINK_W'(1);
			count_q <= '0;
			out_valid_q <= 1'b0;
			pend_q <= 1'b0;
		end else begin
			if (out_valid_q && m_tready && (state_q != S_FIN)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_INIT: begin
					init_q <= init_q + LINK_W'(1);
					if (init_q == HEAD_SLOT) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						cmd_q <= s_tuser;
						value_q <= in_val;
						remain_q <= in_pos - POS_W'(1);
						cur_q <= HEAD_SLOT;
						pend_q <= 1'b0;
						slot_q <= free_q;
						if (!range_ok) begin
							res_q <= ST_RANGE;
							state_q <= S_FIN;
						end else if (s_tuser == CMD_INSERT && free_q == '0) begin
							res_q <= ST_FULL;
							state_q <= S_FIN;
						end else if (s_tuser == CMD_INSERT) begin
							state_q <= S_ALLOC;
						end else begin
							state_q <= S_WALK;
						end
					end
				end
				S_ALLOC: begin
					nfree_q <= link_rdata;
					state_q <= S_WALK;
				end
				S_WALK: begin
					cur_q <= cur;
					pend_q <= 1'b1;
					if (remain_q == '0) begin
						state_q <= S_PRED;
					end else begin
						remain_q <= remain_q - POS_W'(1);
					end
				end
				S_PRED: begin
					pend_q <= 1'b0;
					victim_q <= link_rdata;
					state_q <= (cmd_q == CMD_INSERT) ? S_LINK : S_VICT;
				end
				S_VICT: begin
					state_q <= S_LINK;
				end
				S_LINK: begin
					if (cmd_q == CMD_INSERT) begin
						free_q <= nfree_q;
						count_q <= count_q + CNT_W'(1);
					end else begin
						free_q <= victim_q;
						count_q <= count_q - CNT_W'(1);
					end
					res_q <= ST_OK;
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!out_valid_q || m_tready) begin
						out_q <= {4'b0, count_q, res_q};
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	clle_ram #(
		.WIDTH(LINK_W),
		.DEPTH(SLOTS)
	) u_link_ram (
		.clk  (clk),
		.we   (link_we),
		.waddr(link_waddr),
		.wdata(link_wdata),
		.re   (link_re),
		.raddr(link_raddr),
		.rdata(link_rdata)
	);

	clle_ram #(
		.WIDTH(VAL_W),
		.DEPTH(SLOTS)
	) u_value_ram (
		.clk  (clk),
		.we   (val_we),
		.waddr(slot_q),
		.wdata(value_q),
		.re   (1'b0),
		.raddr(slot_q),
		.rdata()
	);

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for cursor_linked_list_engine_top: edge cases, random list traffic.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import clle_pkg::*;

	typedef struct packed {
		logic [ST_W-1:0]  status;
		logic [CNT_W-1:0] length;
	} list_result_t;

	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int RANDOM_OPS = 560;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic        s_tuser = CMD_INSERT;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;

	logic [LINK_W-1:0] link_mem [SLOTS];
	logic [VAL_W-1:0]  value_mem [SLOTS];
	int unsigned       list_len;
	list_result_t      pending_results [$];

	int fail_count = 0;
	int sent_count = 0;
	int ok_count = 0;
	int range_count = 0;
	int full_count = 0;
	int unsigned peak_len = 0;
	bit sender_calm = 1'b0;
	bit receiver_calm = 1'b0;
	int stall_left = 0;

	cursor_linked_list_engine_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic void clear_list_model();
		for (int i = 0; i < SLOTS; i++) begin
			link_mem[i] = '0;
			value_mem[i] = '0;
		end
		for (int i = 0; i + 2 < SLOTS; i++)
			link_mem[i] = LINK_W'(i + 1);
		list_len = 0;
	endfunction

	function automatic logic [LINK_W-1:0] slot_before(int unsigned pos);
		logic [LINK_W-1:0] cur;
		cur = HEAD_SLOT;
		for (int unsigned i = 1; i < pos; i++)
			cur = link_mem[cur];
		return cur;
	endfunction

	function automatic list_result_t apply_list_op(logic cmd, int unsigned pos,
			logic [VAL_W-1:0] val);
		logic [LINK_W-1:0] slot;
		logic [LINK_W-1:0] pred;
		logic [LINK_W-1:0] victim;
		list_result_t r;
		r.status = ST_OK;
		if (cmd == CMD_INSERT) begin
			if (pos < 1 || pos > list_len + 1) begin
				r.status = ST_RANGE;
			end else if (link_mem[0] == '0) begin
				r.status = ST_FULL;
			end else begin
				slot = link_mem[0];
				link_mem[0] = link_mem[slot];
				value_mem[slot] = val;
				pred = slot_before(pos);
				link_mem[slot] = link_mem[pred];
				link_mem[pred] = slot;
				list_len++;
			end
		end else begin
			if (pos < 1 || pos > list_len) begin
				r.status = ST_RANGE;
			end else begin
				pred = slot_before(pos);
				victim = link_mem[pred];
				link_mem[pred] = link_mem[victim];
				link_mem[victim] = link_mem[0];
				link_mem[0] = victim;
				list_len--;
			end
		end
		r.length = CNT_W'(list_len);
		return r;
	endfunction

	function automatic int draw_wait(bit calm);
		return calm ? 0 : $urandom_range(0, 17);
	endfunction

	task automatic send_item(logic cmd, int unsigned pos, logic [VAL_W-1:0] val);
		int gap;
		list_result_t r;
		if ($urandom_range(0, 47) == 0)
			sender_calm = !sender_calm;
		gap = draw_wait(sender_calm);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {6'd0, val, pos[POS_W-1:0]};
		do @(posedge clk); while (!s_tready);
		r = apply_list_op(cmd, pos, val);
		pending_results.push_back(r);
		sent_count++;
		case (r.status)
			ST_OK:    ok_count++;
			ST_RANGE: range_count++;
			ST_FULL:  full_count++;
			default:  ;
		endcase
		if (list_len > peak_len)
			peak_len = list_len;
	endtask

	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic test_edge_positions();
		send_item(CMD_DELETE, 1, '0);
		send_item(CMD_DELETE, 0, '1);
		send_item(CMD_INSERT, 0, 32'h0000_0001);
		send_item(CMD_INSERT, 2, 32'h0000_0002);
		send_item(CMD_INSERT, SLOTS - 1, 32'h0000_0003);
		send_item(CMD_INSERT, 1, 32'h8000_0000);
		send_item(CMD_INSERT, 1, 32'h7fff_ffff);
		send_item(CMD_INSERT, 3, 32'h0000_0000);
		send_item(CMD_INSERT, 2, 32'hffff_ffff);
		send_item(CMD_INSERT, 5, 32'haaaa_aaaa);
		send_item(CMD_INSERT, 1, 32'h5555_5555);
		send_item(CMD_DELETE, 7, '0);
		send_item(CMD_DELETE, 6, '0);
		send_item(CMD_DELETE, 1, '0);
		send_item(CMD_DELETE, 3, '0);
		send_item(CMD_INSERT, 6, 32'h1234_5678);
		send_item(CMD_DELETE, SLOTS - 1, '0);
		send_item(CMD_DELETE, 1, '0);
		send_item(CMD_DELETE, 1, '0);
		send_item(CMD_DELETE, 1, '0);
		send_item(CMD_DELETE, 1, '0);
	endtask

	task automatic test_random_traffic();
		logic cmd;
		int unsigned span;
		int unsigned pos;
		for (int n = 0; n < RANDOM_OPS; n++) begin
			if (n == RANDOM_OPS / 2)
				wait_for_results();
			if ($urandom_range(0, 4) == 0) begin
				send_item(1'($urandom_range(0, 1)), $urandom_range(0, SLOTS - 1), $urandom());
			end else begin
				if (list_len == 0)
					cmd = CMD_INSERT;
				else if (list_len >= 160)
					cmd = ($urandom_range(0, 3) != 0) ? CMD_DELETE : CMD_INSERT;
				else if (list_len < 8)
					cmd = ($urandom_range(0, 3) != 0) ? CMD_INSERT : CMD_DELETE;
				else
					cmd = 1'($urandom_range(0, 1));
				span = (cmd == CMD_INSERT) ? list_len + 1 : list_len;
				pos = ($urandom_range(0, 5) == 0) ? span : $urandom_range(1, span);
				send_item(cmd, pos, $urandom());
			end
		end
	endtask

	always @(posedge clk) begin
		list_result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected item, expected none, actual status %0d length %0d",
						$time, m_tdata[1:0], m_tdata[11:2]);
				end else begin
					want = pending_results.pop_front();
					if (m_tdata[1:0] !== want.status) begin
						fail_count++;
						$display("%0t: status mismatch, expected %0d, actual %0d",
							$time, want.status, m_tdata[1:0]);
					end
					if (m_tdata[11:2] !== want.length) begin
						fail_count++;
						$display("%0t: list length mismatch, expected %0d, actual %0d",
							$time, want.length, m_tdata[11:2]);
					end
				end
				if ($urandom_range(0, 47) == 0)
					receiver_calm = !receiver_calm;
				stall_left = draw_wait(receiver_calm);
				m_tready <= (stall_left == 0);
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= (stall_left == 0);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("%0t: timeout with %0d items outstanding", $time, pending_results.size());
		$display("** cursor_linked_list_engine_top: FAILED **");
		$finish;
	end

	initial begin
		clear_list_model();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_edge_positions();
		wait_for_results();
		test_random_traffic();
		wait_for_results();
		repeat (SLOTS + 8) @(posedge clk);
		$display("Sent %0d inserts and deletes, peak list length %0d of %0d slots.",
			sent_count, peak_len, SLOTS - 2);
		$display("Outcomes: %0d ok, %0d out of range, %0d list full; %0d mismatches.",
			ok_count, range_count, full_count, fail_count);
		if (fail_count == 0)
			$display("** cursor_linked_list_engine_top: PASSED **");
		else
			$display("** cursor_linked_list_engine_top: FAILED **");
		$finish;
	end

endmodule
